@@ rtl/rfs_pkg.sv @@
`default_nettype none
package rfs_pkg;
  localparam logic [7:0]  PREAMBLE    = 8'hD3;
  localparam logic [23:0] CRC_POLY    = 24'h864CFB;
  localparam logic        CMD_PUSH    = 1'b0;
  localparam logic        CMD_FLUSH   = 1'b1;
  localparam int          OUT_W       = 160;

  typedef struct packed {
    logic [31:0] total_crc_errors;
    logic [31:0] total_frame_bytes;
    logic [31:0] total_frames;
    logic [10:0] bytes_buffered;
    logic [9:0]  last_payload_len;
    logic signed [12:0] last_msg_type;
    logic [10:0] bytes_dropped;
    logic [10:0] crc_failures;
    logic [7:0]  frames_found;
  } rfs_result_t;

  function automatic logic [23:0] crc_byte(input logic [23:0] c, input logic [7:0] b);
    logic [23:0] x;
    x = c ^ {b, 16'h0};
    for (int i = 0; i < 8; i++) begin
      x = x[23] ? ({x[22:0], 1'b0} ^ CRC_POLY) : {x[22:0], 1'b0};
    end
    return x;
  endfunction
endpackage
`default_nettype wire

@@ rtl/rtcm3_frame_sync_crc24q.sv @@
`default_nettype none
// RTCM 3 deframer with CRC-24Q check. Each input transfer (push byte or
// flush) yields exactly one status transfer. Bytes live in a single-port-read
// byte store with a registered read port; the scanner walks it one byte at a
// time (address, then data). A push with fewer than six bytes stored goes
// through scan check, result and idle before the next possible input transfer
// when the output does not stall; a candidate frame is walked over all of its
// payload+6 bytes for the CRC pass, and each slip restarts the walk at the next
// stored byte, so worst case after a mismatch is quadratic in the stored bytes.
// Flush goes from idle straight to the result.
// No clearing pass: the store is tracked by head and count.
module rtcm3_frame_sync_crc24q
  import rfs_pkg::*;
#(
  parameter int STORE_DEPTH = 2048,
  parameter int MAX_PAYLOAD = 1023
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // data_byte
  input  wire logic         in_tuser,   // command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [OUT_W-1:0]  out_tdata   // frames_found, crc_failures, bytes_dropped,
                                        // last_msg_type, last_payload_len,
                                        // bytes_buffered, total_frames,
                                        // total_frame_bytes, total_crc_errors
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RD, S_DATA, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    P_PRE, P_LEN1, P_LEN2, P_CRC, P_W0, P_W1, P_W2
  } phase_t;

  state_t       state_r;
  phase_t       phase_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] pos_r;
  logic [9:0]    plen_r;
  logic [23:0]   crc_r;
  logic [23:0]   want_r;
  logic [11:0]   type_r;
  logic [31:0]   tf_r, tb_r, te_r;
  logic signed [12:0] lt_r;
  logic [9:0]    ll_r;
  logic [7:0]    found_r;
  logic [10:0]   fails_r, drop_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {1'b0, {(CW-AW){1'b0}}, h} + {1'b0, o};
    if (s >= (CW+1)'(STORE_DEPTH)) begin
      s = s - (CW+1)'(STORE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign we    = (state_r == S_IDLE) && in_tvalid && (in_tuser == CMD_PUSH);
  // when full, head + count wraps onto the oldest byte, which is overwritten
  assign waddr = addr_of(head_r, count_r);
  assign raddr = addr_of(head_r, pos_r);

  rfs_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_tdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  rfs_result_t res;
  always_comb begin
    res.frames_found      = found_r;
    res.crc_failures      = fails_r;
    res.bytes_dropped     = drop_r;
    res.last_msg_type     = lt_r;
    res.last_payload_len  = ll_r;
    res.bytes_buffered    = count_r[10:0];
    res.total_frames      = tf_r;
    res.total_frame_bytes = tb_r;
    res.total_crc_errors  = te_r;
    out_tdata = res;
  end

  logic [CW-1:0] flen;
  assign flen = CW'(plen_r) + CW'(6);

  // drop n bytes from head
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] h, input logic [CW-1:0] n,
                                        input logic [CW-1:0] c);
    return (n == c) ? '0 : addr_of(h, n);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= P_PRE;
      head_r  <= '0;
      count_r <= '0;
      pos_r   <= '0;
      tf_r    <= '0;
      tb_r    <= '0;
      te_r    <= '0;
      lt_r    <= -13'sd1;
      ll_r    <= '0;
      found_r <= '0;
      fails_r <= '0;
      drop_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            found_r <= '0;
            fails_r <= '0;
            drop_r  <= '0;
            pos_r   <= '0;
            phase_r <= P_PRE;
            if (in_tuser == CMD_FLUSH) begin
              head_r  <= '0;
              count_r <= '0;
              tf_r    <= '0;
              tb_r    <= '0;
              te_r    <= '0;
              lt_r    <= -13'sd1;
              ll_r    <= '0;
              state_r <= S_OUT;
            end else begin
              if (count_r == CW'(STORE_DEPTH)) begin
                head_r <= addr_of(head_r, CW'(1));
                drop_r <= 11'd1;
              end else begin
                count_r <= count_r + CW'(1);
              end
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (count_r < CW'(6)) begin
            state_r <= S_OUT;
          end else begin
            pos_r   <= '0;
            phase_r <= P_PRE;
            crc_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_DATA;
        end
        S_DATA: begin
          state_r <= S_RD;
          pos_r   <= pos_r + CW'(1);
          case (phase_r)
            P_PRE: begin
              if (rdata == PREAMBLE) begin
                if (pos_r != '0) begin
                  drop_r  <= drop_r + 11'(pos_r);
                  head_r  <= addr_of(head_r, pos_r);
                  count_r <= count_r - pos_r;
                end
                if (count_r - pos_r < CW'(3)) begin
                  state_r <= S_OUT;
                end else begin
                  pos_r   <= CW'(1);
                  crc_r   <= crc_byte(24'h0, rdata);
                  phase_r <= P_LEN1;
                end
              end else if (pos_r + CW'(1) == count_r) begin
                drop_r  <= drop_r + 11'(count_r);
                head_r  <= '0;
                count_r <= '0;
                state_r <= S_OUT;
              end
            end
            P_LEN1: begin
              plen_r[9:8] <= rdata[1:0];
              crc_r       <= crc_byte(crc_r, rdata);
              phase_r     <= P_LEN2;
            end
            P_LEN2: begin
              plen_r[7:0] <= rdata;
              crc_r       <= crc_byte(crc_r, rdata);
              if ({plen_r[9:8], rdata} == 10'd0 ||
                  {plen_r[9:8], rdata} > 10'(MAX_PAYLOAD)) begin
                drop_r  <= drop_r + 11'd1;
                head_r  <= adv(head_r, CW'(1), count_r);
                count_r <= count_r - CW'(1);
                state_r <= S_SCAN;
              end else if (count_r < CW'({plen_r[9:8], rdata}) + CW'(6)) begin
                state_r <= S_OUT;
              end else begin
                phase_r <= P_CRC;
              end
            end
            P_CRC: begin
              crc_r <= crc_byte(crc_r, rdata);
              if (pos_r == CW'(3)) type_r[11:4] <= rdata;
              if (pos_r == CW'(4)) type_r[3:0]  <= rdata[7:4];
              if (pos_r == flen - CW'(4)) phase_r <= P_W0;
            end
            P_W0: begin
              // one-byte payload: low type bits come from the first CRC byte
              if (pos_r == CW'(4)) type_r[3:0] <= rdata[7:4];
              want_r[23:16] <= rdata;
              phase_r <= P_W1;
            end
            P_W1: begin
              want_r[15:8] <= rdata;
              phase_r <= P_W2;
            end
            default: begin
              if ({want_r[23:8], rdata} != crc_r) begin
                fails_r <= fails_r + 11'd1;
                te_r    <= te_r + 32'd1;
                drop_r  <= drop_r + 11'd1;
                head_r  <= adv(head_r, CW'(1), count_r);
                count_r <= count_r - CW'(1);
              end else begin
                lt_r    <= $signed({1'b0, type_r});
                ll_r    <= plen_r;
                head_r  <= adv(head_r, flen, count_r);
                count_r <= count_r - flen;
                found_r <= found_r + 8'd1;
                tf_r    <= tf_r + 32'd1;
                tb_r    <= tb_r + 32'(flen);
              end
              state_r <= S_SCAN;
            end
          endcase
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/rfs_store.sv @@
`default_nettype none
module rfs_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/rfs_checker.sv @@
`default_nettype none
module rfs_checker
  import rfs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             in_tuser,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);
  rfs_result_t r;
  assign r = out_tdata;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> out_tvalid && r.bytes_buffered == 11'd0
      && r.total_frames == 32'd0) else $error("flush not clean");
  a_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.total_frames == 32'd0 |-> r.last_msg_type == -13'sd1)
    else $error("type without frame");
endmodule

bind rtcm3_frame_sync_crc24q rfs_checker u_rfs_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire
